FILE: rtl/core/utf8s_pkg.sv
// ----------------------------------------------------------------------------
// utf8s_pkg
// Shared types and byte/code point constants of the UTF-8 sanitising filter.
// ----------------------------------------------------------------------------
package utf8s_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned HeldDepth  = 3;

  localparam logic [7:0] ByteNul   = 8'h00;
  localparam logic [7:0] ByteTab   = 8'h09;
  localparam logic [7:0] ByteNl    = 8'h0A;
  localparam logic [7:0] ByteSpace = 8'h20;
  localparam logic [7:0] ByteDel   = 8'h7F;
  localparam logic [7:0] CtrlMax   = 8'h1F;
  localparam logic [7:0] AsciiMax  = 8'h7F;

  localparam logic [2:0] SeqNone = 3'd0;
  localparam logic [2:0] SeqTwo  = 3'd2;
  localparam logic [2:0] SeqThree = 3'd3;
  localparam logic [2:0] SeqFour = 3'd4;

  localparam logic [20:0] CpMinTwo   = 21'h00080;
  localparam logic [20:0] CpMinThree = 21'h00800;
  localparam logic [20:0] CpMinFour  = 21'h10000;
  localparam logic [20:0] CpMax      = 21'h10FFFF;
  localparam logic [20:0] C1Min      = 21'h00080;
  localparam logic [20:0] C1Max      = 21'h0009F;

  typedef struct packed {
    logic [7:0] data;
    logic       blanked;
    logic       str_end;
  } res_t;

  typedef struct packed {
    res_t [MaxResults-1:0] ent;
    logic [2:0]            cnt;
  } burst_t;

endpackage

FILE: rtl/core/utf8_sanitize_filter.sv
// ----------------------------------------------------------------------------
// utf8_sanitize_filter
// Streaming UTF-8 sanitising filter for NUL-terminated byte strings.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata         | tlast     | tuser
//  s_axis   | in  | data_byte     | -         | -
//  m_axis   | out | out_byte      | run_last  | [0] string_end, [1] was_blanked
//
//  A byte passes an input register, is classified and lands as a burst of 0 to 4
//  results in the result register. While the receiver is ready, it releases one
//  per cycle and sustained rate is one byte per cycle while each byte yields at
//  most one result; a burst of n results holds the input register until its last
//  result is taken. Reset clears the sequence state and both valid flags.
// ----------------------------------------------------------------------------
module utf8_sanitize_filter import utf8s_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o,
  output logic [1:0] m_axis_tuser_o    // [0] string_end, [1] was_blanked
);

  logic       in_vld_q;
  logic [7:0] in_data_q;
  logic       burst_ready, fire;
  burst_t     burst;
  res_t       res;

  assign fire            = in_vld_q && burst_ready;
  assign s_axis_tready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i;
    end
  end

  utf8s_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .byte_i  (in_data_q),
    .burst_o (burst)
  );

  utf8s_burst u_burst (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .burst_i (burst),
    .ready_o (burst_ready),
    .valid_o (m_axis_tvalid_o),
    .take_i  (m_axis_tready_i),
    .res_o   (res),
    .last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = res.data;
  assign m_axis_tuser_o = {res.blanked, res.str_end};

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> m_axis_tlast_o)
    else $error("string end not last of its burst");

  a_blank_is_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |-> (m_axis_tdata_o == ByteSpace))
    else $error("blanked result is not a space");

  a_hold_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !burst_ready) |=> (in_vld_q && $stable(in_data_q)))
    else $error("pending byte lost while result register busy");

endmodule

FILE: rtl/core/utf8s_decode.sv
// ----------------------------------------------------------------------------
// utf8s_decode
// Sequence state and single-pass classification of one byte into a burst.
// ----------------------------------------------------------------------------
module utf8s_decode import utf8s_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  output burst_t     burst_o
);

  logic [7:0] held_q [HeldDepth];
  logic [2:0] seq_len_q, seq_len_d;
  logic [1:0] held_cnt_q, held_cnt_d;

  logic        is_nul, is_cont, is_ctrl, is_lead, complete, seq_ok;
  logic        emit_cur, cur_blank, flush_blank, store;
  logic [2:0]  lead_len;
  logic [20:0] cp;
  logic        cp_bad;

  always_comb begin
    is_nul  = (byte_i == ByteNul);
    is_cont = (byte_i[7:6] == 2'b10);
    is_ctrl = ((byte_i <= CtrlMax) || (byte_i == ByteDel)) &&
              (byte_i != ByteTab) && (byte_i != ByteNl);
    is_lead = (byte_i[7:5] == 3'b110) || (byte_i[7:4] == 4'b1110) ||
              (byte_i[7:3] == 5'b11110);
    lead_len = (byte_i[7:5] == 3'b110) ? SeqTwo :
               (byte_i[7:4] == 4'b1110) ? SeqThree : SeqFour;
    complete = (({1'b0, held_cnt_q} + 3'd1) >= seq_len_q) || (held_cnt_q == 2'd3);

    case (seq_len_q)
      SeqTwo: begin
        cp     = {10'd0, held_q[0][4:0], byte_i[5:0]};
        cp_bad = (cp < CpMinTwo);
      end
      SeqThree: begin
        cp     = {5'd0, held_q[0][3:0], held_q[1][5:0], byte_i[5:0]};
        cp_bad = (cp < CpMinThree);
      end
      default: begin
        cp     = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0], byte_i[5:0]};
        cp_bad = (cp < CpMinFour) || (cp > CpMax);
      end
    endcase
    seq_ok = !cp_bad && !((cp >= C1Min) && (cp <= C1Max));

    emit_cur    = 1'b0;
    cur_blank   = 1'b0;
    flush_blank = 1'b1;
    store       = 1'b0;
    seq_len_d   = seq_len_q;
    held_cnt_d  = held_cnt_q;

    if (is_nul) begin
      emit_cur   = 1'b1;
      seq_len_d  = SeqNone;
      held_cnt_d = 2'd0;
    end else if (seq_len_q == SeqNone) begin
      if (is_ctrl) begin
        emit_cur  = 1'b1;
        cur_blank = 1'b1;
      end else if (byte_i <= AsciiMax) begin
        emit_cur = 1'b1;
      end else if (is_lead) begin
        store      = 1'b1;
        seq_len_d  = lead_len;
        held_cnt_d = 2'd1;
      end else begin
        emit_cur  = 1'b1;
        cur_blank = 1'b1;
      end
    end else if (!is_cont) begin
      emit_cur   = 1'b1;
      cur_blank  = 1'b1;
      seq_len_d  = SeqNone;
      held_cnt_d = 2'd0;
    end else if (complete) begin
      emit_cur    = 1'b1;
      cur_blank   = !seq_ok;
      flush_blank = !seq_ok;
      seq_len_d   = SeqNone;
      held_cnt_d  = 2'd0;
    end else begin
      store      = 1'b1;
      held_cnt_d = held_cnt_q + 2'd1;
    end

    for (int i = 0; i < MaxResults; i++) begin
      if (i < HeldDepth && 2'(i) < held_cnt_q) begin
        burst_o.ent[i].data    = flush_blank ? ByteSpace : held_q[i % HeldDepth];
        burst_o.ent[i].blanked = flush_blank;
        burst_o.ent[i].str_end = 1'b0;
      end else begin
        burst_o.ent[i].data    = cur_blank ? ByteSpace : byte_i;
        burst_o.ent[i].blanked = cur_blank;
        burst_o.ent[i].str_end = is_nul;
      end
    end
    burst_o.cnt = emit_cur ? ({1'b0, held_cnt_q} + 3'd1) : 3'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q  <= SeqNone;
      held_cnt_q <= 2'd0;
    end else if (fire_i) begin
      seq_len_q  <= seq_len_d;
      held_cnt_q <= held_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < HeldDepth; i++) begin
      if (fire_i && store && (held_cnt_q == 2'(i))) begin
        held_q[i] <= byte_i;
      end
    end
  end

endmodule

FILE: rtl/core/utf8s_burst.sv
// ----------------------------------------------------------------------------
// utf8s_burst
// Result register holding up to four results and releasing one per transaction.
// ----------------------------------------------------------------------------
module utf8s_burst import utf8s_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   load_i,
  input  burst_t burst_i,
  output logic   ready_o,
  output logic   valid_o,
  input  logic   take_i,
  output res_t   res_o,
  output logic   last_o
);

  res_t [MaxResults-1:0] ent_q;
  logic [2:0]            cnt_q;
  logic [1:0]            idx_q;
  logic                  pop;

  assign valid_o = (cnt_q != 3'd0);
  assign pop     = valid_o && take_i;
  assign ready_o = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && take_i);
  assign res_o   = ent_q[idx_q];
  assign last_o  = (cnt_q == 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      idx_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= burst_i.cnt;
      idx_q <= 2'd0;
    end else if (pop) begin
      cnt_q <= cnt_q - 3'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= burst_i.ent;
    end
  end

endmodule

FILE: bench/utf8_sanitize_filter_tb.sv
// ----------------------------------------------------------------------------
// utf8_sanitize_filter_tb
// Self-checking bench for the UTF-8 sanitising filter. Bytes are offered in
// bursts with random gaps and the output side stalls on its own pattern,
// with one long hold-off. Every accepted byte is run through a behavioural
// model of the filter, and each result transaction is compared field by
// field with the oldest expected result.
// ----------------------------------------------------------------------------
module utf8_sanitize_filter_tb import utf8s_pkg::*; ();

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
    logic       was_blanked;
  } filt_res_t;

  class utf8_filter_board;
    logic [7:0] held [HeldDepth];
    logic [2:0] seq_len;
    int         held_cnt;
    filt_res_t  burst [$];
    filt_res_t  expected_results [$];
    int         mismatches;
    int         results_seen;

    function new();
      seq_len      = SeqNone;
      held_cnt     = 0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    function void add_result(input logic [7:0] b, input bit blank, input bit fin);
      filt_res_t r;
      r.out_byte    = blank ? ByteSpace : b;
      r.run_last    = 1'b0;
      r.string_end  = fin;
      r.was_blanked = blank;
      burst.push_back(r);
    endfunction

    function void flush_held(input bit blank);
      for (int i = 0; i < held_cnt; i++) add_result(held[i], blank, 1'b0);
    endfunction

    function bit code_point_ok(input logic [7:0] last);
      logic [20:0] cp;
      bit          ok;
      case (seq_len)
        SeqTwo: begin
          cp = {10'd0, held[0][4:0], last[5:0]};
          ok = cp >= CpMinTwo;
        end
        SeqThree: begin
          cp = {5'd0, held[0][3:0], held[1][5:0], last[5:0]};
          ok = cp >= CpMinThree;
        end
        default: begin
          cp = {held[0][2:0], held[1][5:0], held[2][5:0], last[5:0]};
          ok = cp >= CpMinFour && cp <= CpMax;
        end
      endcase
      if (cp >= C1Min && cp <= C1Max) ok = 1'b0;
      return ok;
    endfunction

    function void note_input(input logic [7:0] b);
      bit ok;
      burst.delete();
      if (b == ByteNul) begin
        if (seq_len != SeqNone) flush_held(1'b1);
        add_result(ByteNul, 1'b0, 1'b1);
        seq_len  = SeqNone;
        held_cnt = 0;
      end else if (seq_len == SeqNone) begin
        if ((b <= CtrlMax || b == ByteDel) && b != ByteTab && b != ByteNl) begin
          add_result(b, 1'b1, 1'b0);
        end else if (b <= AsciiMax) begin
          add_result(b, 1'b0, 1'b0);
        end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
          held[0]  = b;
          held_cnt = 1;
          seq_len  = (b[7:5] == 3'b110) ? SeqTwo : (b[7:4] == 4'b1110) ? SeqThree : SeqFour;
        end else begin
          add_result(b, 1'b1, 1'b0);
        end
      end else if (b[7:6] != 2'b10) begin
        flush_held(1'b1);
        add_result(b, 1'b1, 1'b0);
        seq_len  = SeqNone;
        held_cnt = 0;
      end else if (held_cnt + 1 >= int'(seq_len)) begin
        ok = code_point_ok(b);
        flush_held(!ok);
        add_result(b, !ok, 1'b0);
        seq_len  = SeqNone;
        held_cnt = 0;
      end else begin
        held[held_cnt] = b;
        held_cnt++;
      end
      if (burst.size() > 0) burst[burst.size()-1].run_last = 1'b1;
      foreach (burst[i]) expected_results.push_back(burst[i]);
    endfunction

    task check_output(input logic [7:0] data, input logic last, input logic [1:0] user);
      filt_res_t exp_r;
      results_seen++;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result byte %02h", data));
      end else begin
        exp_r = expected_results.pop_front();
        if (data !== exp_r.out_byte)
          report($sformatf("out_byte %02h, expected %02h", data, exp_r.out_byte));
        if (last !== exp_r.run_last)
          report($sformatf("run_last %b, expected %b", last, exp_r.run_last));
        if (user[0] !== exp_r.string_end)
          report($sformatf("string_end %b, expected %b", user[0], exp_r.string_end));
        if (user[1] !== exp_r.was_blanked)
          report($sformatf("was_blanked %b, expected %b", user[1], exp_r.was_blanked));
      end
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       s_axis_tvalid_i;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i;   // [7:0] data_byte
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i;
  logic [7:0] m_axis_tdata_o;   // [7:0] out_byte
  logic       m_axis_tlast_o;
  logic [1:0] m_axis_tuser_o;   // [0] string_end, [1] was_blanked

  utf8_filter_board board = new();
  int bytes_sent = 0;
  int burst_left = 0;

  logic [7:0] directed_bytes [27] = '{
    8'h41, ByteTab, ByteNl, 8'h01, ByteDel, 8'h80, 8'hFF,
    8'hC3, 8'hA9,
    8'hC0, 8'h80,
    8'hC2, 8'h80,
    8'hED, 8'hA0, 8'h80,
    8'hF4, 8'h90, 8'h80, 8'h80,
    8'hE2, 8'h41,
    8'hF0, 8'h9F, 8'h98, ByteNul,
    ByteNul
  };

  utf8_sanitize_filter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    board.note_input(b);
    bytes_sent++;
    burst_left--;
  endtask

  task automatic send_sequence_start(output int need);
    logic [7:0] lead;
    lead = 8'($urandom_range(8'hC0, 8'hF7));
    need = (lead[7:5] == 3'b110) ? 1 : (lead[7:4] == 4'b1110) ? 2 : 3;
    send_byte(lead);
  endtask

  task automatic send_unit();
    int         kind;
    int         need;
    int         len;
    logic [20:0] cp;
    logic [7:0]  b;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      send_byte(8'($urandom_range(1, 127)));
    end else if (kind < 55) begin
      len = $urandom_range(2, 4);
      case (len)
        2: begin
          cp = 21'($urandom_range(21'h80, 21'h7FF));
          send_byte({3'b110, cp[10:6]});
        end
        3: begin
          cp = 21'($urandom_range(21'h800, 21'hFFFF));
          send_byte({4'b1110, cp[15:12]});
          send_byte({2'b10, cp[11:6]});
        end
        default: begin
          cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
          send_byte({5'b11110, cp[20:18]});
          send_byte({2'b10, cp[17:12]});
          send_byte({2'b10, cp[11:6]});
        end
      endcase
      send_byte({2'b10, cp[5:0]});
    end else if (kind < 70) begin
      send_sequence_start(need);
      repeat (need) send_byte(8'($urandom_range(8'h80, 8'hBF)));
    end else if (kind < 80) begin
      send_sequence_start(need);
      repeat ($urandom_range(0, need - 1)) send_byte(8'($urandom_range(8'h80, 8'hBF)));
      do b = 8'($urandom_range(0, 255)); while (b[7:6] == 2'b10);
      send_byte(b);
    end else if (kind < 92) begin
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 1) == 1) begin
        send_sequence_start(need);
        repeat ($urandom_range(0, need - 1)) send_byte(8'($urandom_range(8'h80, 8'hBF)));
      end
      send_byte(ByteNul);
    end
  endtask

  initial begin : receiver
    int cyc;
    int hold_left;
    bit pressure_done;
    int mode;
    cyc           = 0;
    hold_left     = 0;
    pressure_done = 1'b0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        board.check_output(m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
      cyc++;
      if (!pressure_done && board.results_seen >= 40) begin
        pressure_done = 1'b1;
        hold_left     = 150;
      end
      mode = (cyc / 40) % 4;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= ($urandom_range(0, 1) == 1);
          2: m_axis_tready_i <= (cyc % 3 == 0);
          default: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= 8'h00;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    while (bytes_sent < 170) send_unit();
    s_axis_tvalid_i <= 1'b0;
    for (int w = 0; w < 5000 && board.pending() != 0; w++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (board.pending() != 0)
      board.report($sformatf("%0d results never arrived", board.pending()));
    if (board.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
